>>> rtl/acl_pkg.sv
// ----------------------------------------------------------------------------
// acl_pkg - shared types and constants of the address range access list
// Command encoding, queue entry layout and result layout used by the front
// end, the command queue and the table engine.
// ----------------------------------------------------------------------------
package acl_pkg;

	// address and field widths
	localparam int ADDR_W      = 128;
	localparam int HALF_W      = 64;
	localparam int PLEN_W      = 8;
	localparam int COUNT_OUT_W = 7;
	localparam int IN_DATA_W   = 272;
	localparam int OUT_DATA_W  = 16;

	// v4-mapped addresses carry 0:0:0:0:0:ffff in their upper 96 bits
	localparam int            V4_PREFIX_W = 96;
	localparam logic [V4_PREFIX_W-1:0] V4_PREFIX = 96'h0000_0000_0000_0000_0000_ffff;

	// configuration register indexes
	localparam logic CFG_ANY_V4 = 1'b0;
	localparam logic CFG_ANY_V6 = 1'b1;

	// item kind on the input tuser
	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// operation handed from the front end to the table engine
	typedef enum logic [1:0] {
		OP_LOOKUP,
		OP_ADD,
		OP_CLEAR,
		OP_NONE
	} op_t;

	// queue entry: lookup uses lo_addr as the key; add stores lo_addr..hi_addr
	typedef struct packed {
		op_t              op;
		logic             v4;
		logic [ADDR_W-1:0] lo_addr;
		logic [ADDR_W-1:0] hi_addr;
	} cmd_t;

	// result item, matched in the lowest bit
	typedef struct packed {
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   status;
		logic                   matched;
	} res_t;

endpackage

>>> rtl/acl_front.sv
// ----------------------------------------------------------------------------
// acl_front - input stage of the access list
// Accepts input transfers, decodes the kind, builds the masked range bounds
// of an add and tags v4-mapped lookup keys, then hands a command onward.
// ----------------------------------------------------------------------------
module acl_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [acl_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  logic [1:0]                    s_axis_tuser,
	output logic                          push_valid,
	input  logic                          push_ready,
	output acl_pkg::cmd_t                 push_cmd
);
	import acl_pkg::*;

	logic              valid_s1;
	cmd_t              cmd_s1;
	cmd_t              cmd_d;
	logic [HALF_W-1:0] addr_high, addr_low, second_high, second_low;
	logic              has_second;
	logic [PLEN_W-1:0] prefix_len;
	logic [ADDR_W-1:0] addr, range_end, mask;
	logic              accept;

	// unpack the input transfer
	assign addr_high   = s_axis_tdata[HALF_W-1:0];
	assign addr_low    = s_axis_tdata[2*HALF_W-1:HALF_W];
	assign second_high = s_axis_tdata[3*HALF_W-1:2*HALF_W];
	assign second_low  = s_axis_tdata[4*HALF_W-1:3*HALF_W];
	assign has_second  = s_axis_tdata[4*HALF_W];
	assign prefix_len  = s_axis_tdata[4*HALF_W+PLEN_W:4*HALF_W+1];

	assign addr      = {addr_high, addr_low};
	assign range_end = has_second ? {second_high, second_low} : addr;
	// a shift of 128 or more leaves zero, so long prefixes give an exact mask
	assign mask      = ~({ADDR_W{1'b1}} >> prefix_len);

	// classify the item
	always_comb begin
		cmd_d.v4 = (addr[ADDR_W-1:ADDR_W-V4_PREFIX_W] == V4_PREFIX);
		cmd_d.lo_addr = addr;
		cmd_d.hi_addr = range_end;
		case (s_axis_tuser)
			KIND_LOOKUP: begin
				cmd_d.op = OP_LOOKUP;
			end
			KIND_ADD: begin
				cmd_d.op = OP_ADD;
				cmd_d.lo_addr = addr & mask;
				cmd_d.hi_addr = range_end | ~mask;
			end
			KIND_CLEAR: begin
				cmd_d.op = OP_CLEAR;
			end
			default: begin
				cmd_d.op = OP_NONE;
			end
		endcase
	end

	assign s_axis_tready = !valid_s1 || push_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// hold one classified command until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

>>> rtl/acl_cmd_fifo.sv
// ----------------------------------------------------------------------------
// acl_cmd_fifo - two-entry command queue
// Decouples the front end from the table engine so either side can stall.
// ----------------------------------------------------------------------------
module acl_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  acl_pkg::cmd_t wr_cmd,
	output logic          rd_valid,
	input  logic          rd_ready,
	output acl_pkg::cmd_t rd_cmd
);
	import acl_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   fill_q;
	logic             do_wr, do_rd;

	assign wr_ready = (fill_q != (PTR_W+1)'(DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + (PTR_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

>>> rtl/acl_back.sv
// ----------------------------------------------------------------------------
// acl_back - range table engine
// Holds the range memory and the entry count, appends ranges, clears the
// table and scans stored ranges one per cycle for a lookup.
// ----------------------------------------------------------------------------
module acl_back #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          any_v4,
	input  logic          any_v6,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  acl_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output acl_pkg::res_t res
);
	import acl_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int EXT_W = CNT_W + COUNT_OUT_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q, scan_q, count_inc;
	logic                pend_q;
	logic                res_valid_q;
	res_t                res_q;
	logic [ADDR_W-1:0]   key_q;
	logic [2*ADDR_W-1:0] mem [TABLE_DEPTH];
	logic [2*ADDR_W-1:0] rd_data_q;
	logic                slot_free, take, any_hit, table_full;
	logic                hit, finish, wr_en, rd_en;
	logic [EXT_W-1:0]    ext_cur, ext_inc;

	assign slot_free  = !res_valid_q || res_ready;
	assign cmd_ready  = (state_q == ST_IDLE) && slot_free;
	assign take       = cmd_valid && cmd_ready;
	assign any_hit    = (any_v4 && cmd.v4) || (any_v6 && !cmd.v4);
	assign table_full = (count_q == DEPTH_C);
	assign count_inc  = count_q + CNT_W'(1);
	assign ext_cur    = EXT_W'(count_q);
	assign ext_inc    = EXT_W'(count_inc);

	// compare the entry read last cycle against the key
	assign hit    = pend_q && (rd_data_q[2*ADDR_W-1:ADDR_W] <= key_q)
	                && (key_q <= rd_data_q[ADDR_W-1:0]);
	assign finish = hit || (scan_q == count_q);
	assign wr_en  = take && (cmd.op == OP_ADD) && !table_full;
	assign rd_en  = (state_q == ST_SCAN) && !finish;

	// range memory: first bound in the upper half, last bound in the lower
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IDX_W-1:0]] <= {cmd.lo_addr, cmd.hi_addr};
		end
		if (rd_en) begin
			rd_data_q <= mem[scan_q[IDX_W-1:0]];
		end
	end

	// capture the lookup key
	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= cmd.lo_addr;
		end
	end

	// sequence commands and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						res_q.matched     <= 1'b0;
						res_q.status      <= 1'b0;
						res_q.entry_count <= ext_cur[COUNT_OUT_W-1:0];
						res_valid_q       <= 1'b1;
						case (cmd.op)
							OP_LOOKUP: begin
								if (any_hit) begin
									res_q.matched <= 1'b1;
								end else if (count_q != '0) begin
									res_valid_q <= res_valid_q && !res_ready;
									state_q     <= ST_SCAN;
									scan_q      <= '0;
									pend_q      <= 1'b0;
								end
							end
							OP_ADD: begin
								if (table_full) begin
									res_q.status <= 1'b1;
								end else begin
									count_q           <= count_inc;
									res_q.entry_count <= ext_inc[COUNT_OUT_W-1:0];
								end
							end
							OP_CLEAR: begin
								count_q           <= '0;
								res_q.entry_count <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (finish) begin
						if (slot_free) begin
							res_q.matched     <= hit;
							res_q.status      <= 1'b0;
							res_q.entry_count <= ext_cur[COUNT_OUT_W-1:0];
							res_valid_q       <= 1'b1;
							pend_q            <= 1'b0;
							state_q           <= ST_IDLE;
						end
					end else begin
						scan_q <= scan_q + CNT_W'(1);
						pend_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> rtl/ip_range_acl_match.sv
// ----------------------------------------------------------------------------
// ip_range_acl_match - 128-bit address range access list
// Front end, command queue and range table engine with a result register.
// ----------------------------------------------------------------------------
// A lookup is answered directly from the idle state when a match-any
// register decides it or the table is empty; otherwise the engine scans the
// stored ranges, reading the range memory one entry per cycle, and stops at
// the first containing range. Add, clear and unknown kinds are also answered
// from the idle state. The front end and the queue each register a command,
// and the two-entry queue lets the front end keep accepting while a scan
// runs. No clearing pass after reset: only entries below the count are ever
// read.
// ----------------------------------------------------------------------------
module ip_range_acl_match #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic                           cfg_wdata,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// addr_high[63:0], addr_low[127:64], second_high[191:128],
	// second_low[255:192], has_second[256], prefix_len[264:257], zero fill
	input  logic [acl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]                     s_axis_tuser,
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// matched[0], status[1], entry_count[8:2], zero fill
	output logic [acl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import acl_pkg::*;

	logic any_v4_q, any_v6_q;
	logic front_valid, front_ready, back_valid, back_ready;
	cmd_t front_cmd, back_cmd;
	res_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_v4_q <= 1'b0;
			any_v6_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ANY_V4: any_v4_q <= cfg_wdata;
				CFG_ANY_V6: any_v6_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	acl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push_valid    (front_valid),
		.push_ready    (front_ready),
		.push_cmd      (front_cmd)
	);

	acl_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_cmd   (front_cmd),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_cmd   (back_cmd)
	);

	acl_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.any_v4    (any_v4_q),
		.any_v6    (any_v6_q),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {(OUT_DATA_W - $bits(res_t))'(0), res};

endmodule

>>> rtl/acl_checker.sv
// ----------------------------------------------------------------------------
// acl_checker - port-level checks of the access list
// Watches the result stream for inconsistent results and unstable stalls.
// ----------------------------------------------------------------------------
module acl_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [acl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import acl_pkg::*;

	localparam logic [COUNT_OUT_W-1:0] DEPTH_OUT = COUNT_OUT_W'(TABLE_DEPTH);

	// a result is never both a match and a dropped add
	a_match_xor_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("matched and status both set");

	// a dropped add reports a full table
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[8:2] == DEPTH_OUT))
		else $error("status set with table not full");

	// the count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((TABLE_DEPTH > 127) || (m_axis_tdata[8:2] <= DEPTH_OUT)))
		else $error("entry count above table depth");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while stalled");

endmodule

bind ip_range_acl_match acl_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_acl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
